### rtl/fcct_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// cluster chain table. No dependencies.
package fcct_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int SCAN_W        = IDX_W + 1;
   localparam int CNT_W         = 8;
   localparam int DATA_W        = 32;

   localparam logic [CNT_W-1:0]  CNT_RESET          = 8'd128;
   localparam logic [DATA_W-1:0] ALL_ONES           = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] CHAIN_MASK         = 32'h0FFF_FFFF;
   localparam logic [DATA_W-1:0] END_OF_CHAIN       = 32'h0FFF_FFF8;
   localparam logic [DATA_W-1:0] FIRST_DATA_CLUSTER = 32'd2;

   typedef enum logic [1:0] {
      ACT_LOAD     = 2'd0,
      ACT_READ     = 2'd1,
      ACT_NEXT     = 2'd2,
      ACT_ALLOCATE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_NO_FREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WR_LOAD = 2'd0,
      WR_MARK = 2'd1,
      WR_LINK = 2'd2
   } wr_sel_type;

   typedef enum logic [2:0] {
      RES_LOAD    = 3'd0,
      RES_RAW     = 3'd1,
      RES_MASKED  = 3'd2,
      RES_ALLOC   = 3'd3,
      RES_INVALID = 3'd4,
      RES_NO_FREE = 3'd5
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mem_we;
      wr_sel_type  wr_sel;
      logic        rd_en;
      logic        rd_scan;
      logic        scan_init;
      logic        scan_inc;
      logic        found_load;
      logic        res_load;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       in_table;
      logic       next_ok;
      logic       link_ok;
      logic       alloc_ok;
      logic       entry_zero;
      logic       scan_done;
      logic       out_free;
   } stat_type;

endpackage

### rtl/fat_cluster_chain_table.sv
// FAT32 cluster chain table, top level. Joins fcct_ctrl and fcct_datapath.
// Depends on fcct_pkg.
//
// Usage:
//   req_* carries one transaction: tuser = action (load, read, next,
//   allocate), tdata = cluster and entry value. rsp_* returns exactly one
//   transaction per request: tuser = status, tdata = value (all ones on error).
//   csr_* writes cluster_count; it is always ready and should only be written
//   while no request is in flight.
// Sequence (one request in flight at a time):
//   load or rejected request: decode, result register, output register
//   read / next: decode, memory read, result register, output register
//   allocate: scan entries from cluster 2 up, mark the first free one, then
//   write the link when cluster is nonzero and in the table; the scan reads
//   one entry per cycle through the single memory read port.
// Reset: synchronous; all entries read as free, cluster_count = 128,
//   rsp_tvalid low.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next request is still accepted and processed, then held until the
//   output register drains.
module fat_cluster_chain_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] cluster, [63:32] entry_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata    // cluster_count
);

   fcct_pkg::cmd_type  cmd;
   fcct_pkg::stat_type stat;

   fcct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fcct_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_tuser),
      .req_cluster     (req_tdata[31:0]),
      .req_entry_value (req_tdata[63:32]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_value       (rsp_tdata),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

### rtl/fcct_ctrl.sv
// Sequencer for the cluster chain table: decodes each transaction and
// steps the datapath through lookup, scan, mark and link. Uses fcct_pkg.
module fcct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  fcct_pkg::stat_type stat,
   output fcct_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_SCAN_FIRST,
      ST_SCAN,
      ST_MARK,
      ST_LINK,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.wr_sel  = fcct_pkg::WR_LOAD;
      cmd.res_sel = fcct_pkg::RES_INVALID;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.action)
               fcct_pkg::ACT_LOAD: begin
                  cmd.res_load = 1'b1;
                  state_in     = ST_EMIT;
                  if (stat.in_table) begin
                     cmd.mem_we  = 1'b1;
                     cmd.wr_sel  = fcct_pkg::WR_LOAD;
                     cmd.res_sel = fcct_pkg::RES_LOAD;
                  end
               end
               fcct_pkg::ACT_READ: begin
                  if (stat.in_table) begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_READ_WAIT;
                  end else begin
                     cmd.res_load = 1'b1;
                     state_in     = ST_EMIT;
                  end
               end
               fcct_pkg::ACT_NEXT: begin
                  if (stat.next_ok) begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_READ_WAIT;
                  end else begin
                     cmd.res_load = 1'b1;
                     state_in     = ST_EMIT;
                  end
               end
               default: begin
                  if (stat.alloc_ok) begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN_FIRST;
                  end else begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = fcct_pkg::RES_NO_FREE;
                     state_in     = ST_EMIT;
                  end
               end
            endcase
         end
         ST_READ_WAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = (stat.action == fcct_pkg::ACT_NEXT) ?
                           fcct_pkg::RES_MASKED : fcct_pkg::RES_RAW;
            state_in     = ST_EMIT;
         end
         ST_SCAN_FIRST: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_scan  = 1'b1;
            cmd.scan_inc = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.entry_zero) begin
               cmd.found_load = 1'b1;
               state_in       = ST_MARK;
            end else if (stat.scan_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = fcct_pkg::RES_NO_FREE;
               state_in     = ST_EMIT;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_scan  = 1'b1;
               cmd.scan_inc = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = fcct_pkg::WR_MARK;
            if (stat.link_ok) begin
               state_in = ST_LINK;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = fcct_pkg::RES_ALLOC;
               state_in     = ST_EMIT;
            end
         end
         ST_LINK: begin
            cmd.mem_we   = 1'b1;
            cmd.wr_sel   = fcct_pkg::WR_LINK;
            cmd.res_load = 1'b1;
            cmd.res_sel  = fcct_pkg::RES_ALLOC;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/fcct_datapath.sv
// Datapath for the cluster chain table: entry memory with valid bits,
// transaction registers, scan counter, result and output registers. Uses fcct_pkg.
module fcct_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_action,
   input  logic [fcct_pkg::DATA_W-1:0]   req_cluster,
   input  logic [fcct_pkg::DATA_W-1:0]   req_entry_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fcct_pkg::CNT_W-1:0]    csr_wdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [1:0]                    rsp_status,
   output logic [fcct_pkg::DATA_W-1:0]   rsp_value,
   input  fcct_pkg::cmd_type             cmd,
   output fcct_pkg::stat_type            stat
);

   logic [fcct_pkg::DATA_W-1:0]        mem [fcct_pkg::TABLE_ENTRIES];
   logic [fcct_pkg::TABLE_ENTRIES-1:0] valid_ff;

   logic [fcct_pkg::CNT_W-1:0]  count_ff;
   fcct_pkg::action_type        action_ff;
   logic [fcct_pkg::DATA_W-1:0] cluster_ff;
   logic [fcct_pkg::DATA_W-1:0] entry_ff;
   logic [fcct_pkg::SCAN_W-1:0] scan_ff;
   logic [fcct_pkg::IDX_W-1:0]  found_ff;
   logic [fcct_pkg::DATA_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;
   logic [fcct_pkg::IDX_W-1:0]  rd_idx_ff;
   logic [1:0]                  res_status_ff;
   logic [fcct_pkg::DATA_W-1:0] res_value_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic [fcct_pkg::DATA_W-1:0] rsp_value_ff;

   logic [fcct_pkg::SCAN_W-1:0] lim;
   logic [fcct_pkg::IDX_W-1:0]  rd_addr;
   logic [fcct_pkg::IDX_W-1:0]  wr_addr;
   logic [fcct_pkg::DATA_W-1:0] wr_data;
   logic [fcct_pkg::DATA_W-1:0] rd_entry;
   logic [1:0]                  res_status_in;
   logic [fcct_pkg::DATA_W-1:0] res_value_in;

   assign csr_ready = 1'b1;

   assign lim = (32'(count_ff) >= fcct_pkg::TABLE_ENTRIES) ?
                fcct_pkg::SCAN_W'(fcct_pkg::TABLE_ENTRIES) :
                fcct_pkg::SCAN_W'(count_ff);

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;
   assign rd_addr  = cmd.rd_scan ? scan_ff[fcct_pkg::IDX_W-1:0]
                                 : cluster_ff[fcct_pkg::IDX_W-1:0];
   assign wr_addr  = (cmd.wr_sel == fcct_pkg::WR_MARK) ? found_ff
                                                      : cluster_ff[fcct_pkg::IDX_W-1:0];

   always_comb begin
      case (cmd.wr_sel)
         fcct_pkg::WR_MARK: wr_data = fcct_pkg::END_OF_CHAIN;
         fcct_pkg::WR_LINK: wr_data = fcct_pkg::DATA_W'(found_ff);
         default:           wr_data = entry_ff;
      endcase
   end

   always_comb begin
      stat.action     = action_ff;
      stat.in_table   = (cluster_ff < fcct_pkg::TABLE_ENTRIES);
      stat.next_ok    = (cluster_ff >= fcct_pkg::FIRST_DATA_CLUSTER) &&
                        (cluster_ff < fcct_pkg::DATA_W'(lim));
      stat.link_ok    = (cluster_ff != '0) &&
                        (cluster_ff < fcct_pkg::TABLE_ENTRIES);
      stat.alloc_ok   = (fcct_pkg::DATA_W'(lim) > fcct_pkg::FIRST_DATA_CLUSTER);
      stat.entry_zero = (rd_entry == '0);
      stat.scan_done  = (scan_ff >= lim);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      res_status_in = fcct_pkg::STAT_OK;
      res_value_in  = fcct_pkg::ALL_ONES;
      case (cmd.res_sel)
         fcct_pkg::RES_LOAD:    res_value_in = entry_ff;
         fcct_pkg::RES_RAW:     res_value_in = rd_entry;
         fcct_pkg::RES_MASKED:  res_value_in = rd_entry & fcct_pkg::CHAIN_MASK;
         fcct_pkg::RES_ALLOC:   res_value_in = fcct_pkg::DATA_W'(found_ff);
         fcct_pkg::RES_NO_FREE: res_status_in = fcct_pkg::STAT_NO_FREE;
         default:               res_status_in = fcct_pkg::STAT_INVALID;
      endcase
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
      if (cmd.capture) begin
         action_ff  <= fcct_pkg::action_type'(req_action);
         cluster_ff <= req_cluster;
         entry_ff   <= req_entry_value;
      end
      if (cmd.scan_init) begin
         scan_ff <= fcct_pkg::SCAN_W'(fcct_pkg::FIRST_DATA_CLUSTER);
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.found_load) begin
         found_ff <= rd_idx_ff;
      end
      if (cmd.res_load) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= fcct_pkg::CNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_wdata;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

### rtl/fcct_checker.sv
// Port-level checks for fat_cluster_chain_table, bound to the top level.
// Depends on fcct_pkg.
module fcct_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == fcct_pkg::STAT_OK ||
                      rsp_tuser == fcct_pkg::STAT_INVALID ||
                      rsp_tuser == fcct_pkg::STAT_NO_FREE))
      else $error("undefined status code");

   a_error_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != fcct_pkg::STAT_OK) |->
      (rsp_tdata == fcct_pkg::ALL_ONES))
      else $error("error status without all-ones value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind fat_cluster_chain_table fcct_checker u_fcct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/fat_cluster_chain_table_checker.sv
// Checker for the cluster chain table: watches request, result and csr channels,
// keeps its own image of the table and cluster_count, and compares every result.
// Depends on fcct_pkg.
`timescale 1ns / 1ps

module fat_cluster_chain_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_wdata,
   output int          mismatches,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      fcct_pkg::status_type        status;
      logic [fcct_pkg::DATA_W-1:0] value;
   } chain_reply_type;

   logic [fcct_pkg::DATA_W-1:0] fat_image [fcct_pkg::TABLE_ENTRIES];
   logic [fcct_pkg::CNT_W-1:0]  count_reg;
   chain_reply_type             expected_replies [$];

   function automatic chain_reply_type chain_table_step(fcct_pkg::action_type act,
                                                        logic [31:0] cl,
                                                        logic [31:0] ev);
      chain_reply_type r;
      int              lim;
      bit              found;
      r.status = fcct_pkg::STAT_INVALID;
      r.value  = fcct_pkg::ALL_ONES;
      found    = 1'b0;
      lim      = (count_reg > fcct_pkg::TABLE_ENTRIES) ? fcct_pkg::TABLE_ENTRIES
                                                       : int'(count_reg);
      case (act)
         fcct_pkg::ACT_LOAD: begin
            if (cl < fcct_pkg::TABLE_ENTRIES) begin
               fat_image[cl[fcct_pkg::IDX_W-1:0]] = ev;
               r.status = fcct_pkg::STAT_OK;
               r.value  = ev;
            end
         end
         fcct_pkg::ACT_READ: begin
            if (cl < fcct_pkg::TABLE_ENTRIES) begin
               r.status = fcct_pkg::STAT_OK;
               r.value  = fat_image[cl[fcct_pkg::IDX_W-1:0]];
            end
         end
         fcct_pkg::ACT_NEXT: begin
            if (cl >= fcct_pkg::FIRST_DATA_CLUSTER && cl < lim) begin
               r.status = fcct_pkg::STAT_OK;
               r.value  = fat_image[cl[fcct_pkg::IDX_W-1:0]] & fcct_pkg::CHAIN_MASK;
            end
         end
         default: begin
            r.status = fcct_pkg::STAT_NO_FREE;
            for (int i = 2; i < lim; i++) begin
               if (!found && fat_image[i] == '0) begin
                  found        = 1'b1;
                  fat_image[i] = fcct_pkg::END_OF_CHAIN;
                  // link goes in after the mark, so prev == new ends up self-linked
                  if (cl != 0 && cl < fcct_pkg::TABLE_ENTRIES)
                     fat_image[cl[fcct_pkg::IDX_W-1:0]] =
                        fcct_pkg::DATA_W'(i) & fcct_pkg::CHAIN_MASK;
                  r.status = fcct_pkg::STAT_OK;
                  r.value  = fcct_pkg::DATA_W'(i) & fcct_pkg::CHAIN_MASK;
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s: expected %h, got %h", $time, what, exp_v, got_v);
   endtask

   always @(posedge clock) begin
      chain_reply_type want;
      if (reset) begin
         foreach (fat_image[i]) fat_image[i] = '0;
         count_reg = fcct_pkg::CNT_RESET;
         expected_replies.delete();
         mismatches = 0;
         checked    = 0;
         pending    = 0;
      end else begin
         if (csr_valid && csr_ready)
            count_reg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_replies.size() == 0) begin
               flag_mismatch("result with no request pending", '0, rsp_tdata);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tuser !== want.status)
                  flag_mismatch("status", 32'(want.status), 32'(rsp_tuser));
               if (rsp_tdata !== want.value)
                  flag_mismatch("value", want.value, rsp_tdata);
            end
         end
         if (req_tvalid && req_tready)
            expected_replies.push_back(
               chain_table_step(fcct_pkg::action_type'(req_tuser),
                                req_tdata[31:0], req_tdata[63:32]));
         pending = expected_replies.size();
      end
   end

endmodule

### test/tb_fat_cluster_chain_table.sv
// Testbench top for the cluster chain table: clock, reset, directed and random
// transactions over several cluster_count settings, and the verdict.
// Depends on fcct_pkg, fat_cluster_chain_table and fat_cluster_chain_table_checker.
`timescale 1ns / 1ps

module tb_fat_cluster_chain_table;

   localparam int PHASES      = 10;
   localparam int HOLD_CYCLES = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [7:0]  csr_wdata  = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;
   wire  [1:0]  rsp_tuser;
   wire         csr_ready;

   int fail_count;
   int pending_count;
   int checked_count;

   bit steady      = 1'b0;
   bit hold_armed  = 1'b0;
   bit hold_served = 1'b0;

   int requests_sent;
   int allocs_sent;
   int count_writes;

   int         phase_items [PHASES] = '{30, 30, 120, 40, 100, 100, 20, 100, 60, 100};
   logic [7:0] phase_count [PHASES] = '{8'd2, 8'd0, 8'd255, 8'd3, 8'd40, 8'd128,
                                        8'd1, 8'd200, 8'd17, 8'd128};

   always #1 clock = ~clock;

   fat_cluster_chain_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   fat_cluster_chain_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .mismatches (fail_count),
      .pending    (pending_count),
      .checked    (checked_count)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_cluster();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, fcct_pkg::TABLE_ENTRIES - 1);
      if (r < 75) return $urandom_range(0, 12);
      if (r < 88) return $urandom_range(fcct_pkg::TABLE_ENTRIES - 4,
                                        fcct_pkg::TABLE_ENTRIES + 3);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_entry();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return '0;
      if (r < 60) return $urandom_range(2, fcct_pkg::TABLE_ENTRIES - 1);
      if (r < 70) return fcct_pkg::END_OF_CHAIN | $urandom_range(0, 7);
      return $urandom;
   endfunction

   // one request transaction; valid stays up when no gap follows
   task automatic offer(fcct_pkg::action_type act, logic [31:0] cl, logic [31:0] ev);
      int g;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {ev, cl};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      requests_sent++;
      if (act == fcct_pkg::ACT_ALLOCATE) allocs_sent++;
      g = steady ? 0 : pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic offer_random();
      int                   r;
      fcct_pkg::action_type act;
      logic [31:0]          cl;
      r  = $urandom_range(0, 99);
      cl = pick_cluster();
      if (r < 30) act = fcct_pkg::ACT_LOAD;
      else if (r < 48) act = fcct_pkg::ACT_READ;
      else if (r < 68) act = fcct_pkg::ACT_NEXT;
      else begin
         act = fcct_pkg::ACT_ALLOCATE;
         if ($urandom_range(0, 3) == 0) cl = '0;
      end
      offer(act, cl, pick_entry());
   endtask

   task automatic drain(int limit);
      int n;
      n = 0;
      @(negedge clock);
      while (pending_count != 0 && n < limit) begin
         @(negedge clock);
         n++;
      end
   endtask

   task automatic write_cluster_count(logic [7:0] v);
      drain(5000);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      count_writes++;
   endtask

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else begin
            n = steady ? 0 : pick_gap();
            if (n == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (n - 1) @(posedge clock);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("run stopped at time limit, %0d results outstanding", pending_count);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // table bounds, chain masking, allocate linking
      offer(fcct_pkg::ACT_READ, 32'd0, $urandom);
      offer(fcct_pkg::ACT_READ, 32'd127, '0);
      offer(fcct_pkg::ACT_READ, 32'd128, '0);
      offer(fcct_pkg::ACT_READ, 32'hFFFF_FFFF, '0);
      offer(fcct_pkg::ACT_NEXT, 32'd0, '0);
      offer(fcct_pkg::ACT_NEXT, 32'd1, '0);
      offer(fcct_pkg::ACT_NEXT, 32'd2, '0);
      offer(fcct_pkg::ACT_LOAD, 32'd5, 32'hFFFF_FFFF);
      offer(fcct_pkg::ACT_NEXT, 32'd5, '0);
      offer(fcct_pkg::ACT_LOAD, 32'h8000_0000, 32'h0000_1234);
      offer(fcct_pkg::ACT_LOAD, 32'd127, 32'hA5A5_A5A5);
      offer(fcct_pkg::ACT_READ, 32'd127, '0);
      offer(fcct_pkg::ACT_ALLOCATE, 32'd0, '0);
      offer(fcct_pkg::ACT_ALLOCATE, 32'd2, '0);
      offer(fcct_pkg::ACT_NEXT, 32'd2, '0);
      offer(fcct_pkg::ACT_ALLOCATE, 32'd4, '0);
      offer(fcct_pkg::ACT_READ, 32'd4, '0);
      offer(fcct_pkg::ACT_ALLOCATE, 32'd200, '0);
      offer(fcct_pkg::ACT_ALLOCATE, 32'd127, '0);
      offer(fcct_pkg::ACT_NEXT, 32'd127, '0);
      offer(fcct_pkg::ACT_LOAD, 32'd127, 32'd0);
      offer(fcct_pkg::ACT_NEXT, 32'd127, '0);
      offer(fcct_pkg::ACT_LOAD, 32'd0, fcct_pkg::END_OF_CHAIN);
      offer(fcct_pkg::ACT_LOAD, 32'd1, 32'hFFFF_FFFF);
      offer(fcct_pkg::ACT_READ, 32'd1, '0);
      req_tvalid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         write_cluster_count(phase_count[p]);
         steady <= (p % 3 == 1);
         if (phase_count[p] == 8'd255) hold_armed <= 1'b1;
         // in tiny volumes, probe the cutoff right away
         if (phase_count[p] < 8'd4) begin
            offer(fcct_pkg::ACT_NEXT, 32'd2, '0);
            offer(fcct_pkg::ACT_ALLOCATE, 32'd0, '0);
         end
         for (int i = 0; i < phase_items[p]; i++) offer_random();
         req_tvalid <= 1'b0;
      end

      drain(5000);
      repeat (20) @(posedge clock);
      $display("%0d requests (%0d allocate) over %0d cluster_count settings",
               requests_sent, allocs_sent, count_writes);
      $display("%0d results checked, %0d outstanding", checked_count, pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
